// ===== rtl/bfc_pkg.sv =====
`timescale 1ns / 1ps
package bfc_pkg;

	localparam int NUM_ROWS    = 4;
	localparam int NUM_CORNERS = 8;
	localparam int NUM_PLANES  = 6;
	localparam int ONE_SHIFT   = 8;

	typedef logic signed [15:0] coord_t;
	typedef logic signed [15:0] coef_t;
	typedef logic signed [31:0] prod_t;
	typedef logic signed [32:0] psum_t;
	typedef logic signed [33:0] clip_t;
	typedef logic signed [34:0] cmp_t;
	typedef logic [2:0]         cfg_idx_t;
	typedef logic [63:0]        row_t;
	typedef logic [NUM_PLANES-1:0] plane_mask_t;

	localparam cfg_idx_t REG_CLIP_ROW_X = 3'd0;
	localparam cfg_idx_t REG_CLIP_ROW_Y = 3'd1;
	localparam cfg_idx_t REG_CLIP_ROW_Z = 3'd2;
	localparam cfg_idx_t REG_CLIP_ROW_W = 3'd3;

	localparam row_t ROW_X_RESET = 64'h0000_0000_0000_1000;
	localparam row_t ROW_Y_RESET = 64'h0000_0000_1000_0000;
	localparam row_t ROW_Z_RESET = 64'h0000_1000_0000_0000;
	localparam row_t ROW_W_RESET = 64'h1000_0000_0000_0000;

	localparam int ROW_X = 0;
	localparam int ROW_Y = 1;
	localparam int ROW_Z = 2;
	localparam int ROW_W = 3;

endpackage

// ===== rtl/box_frustum_cull_top.sv =====
`timescale 1ns / 1ps
// Results: a request taken into v_s1 moves on through v_s2 and v_s3 to v_s4,
// which drives the done strobe together with the registered visible bit.
// Throughput: one box per cycle through four register stages (products,
// pair sums, corner sums, plane compares); busy never rises.
// Reset clears the valid bits and restores the identity matrix rows.
// The receiver cannot stall: each result shows for exactly one cycle.
module box_frustum_cull_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  bfc_pkg::coord_t    box_min_x,
	input  bfc_pkg::coord_t    box_min_y,
	input  bfc_pkg::coord_t    box_min_z,
	input  bfc_pkg::coord_t    box_max_x,
	input  bfc_pkg::coord_t    box_max_y,
	input  bfc_pkg::coord_t    box_max_z,
	output logic               done,
	output logic               visible,
	input  logic               cfg_we,
	input  bfc_pkg::cfg_idx_t  cfg_index,
	input  bfc_pkg::row_t      cfg_data
);
	import bfc_pkg::*;

	row_t        row_q [NUM_ROWS];

	logic        v_s1, v_s2, v_s3, v_s4;
	prod_t       prod_s1   [NUM_ROWS][6];
	coef_t       wcoef_s1  [NUM_ROWS];
	psum_t       xy_s2     [NUM_ROWS][4];
	psum_t       zk_s2     [NUM_ROWS][2];
	clip_t       corner_s3 [NUM_ROWS][NUM_CORNERS];
	logic        visible_s4;

	prod_t       prod_d    [NUM_ROWS][6];
	coef_t       wcoef_d   [NUM_ROWS];
	psum_t       xy_d      [NUM_ROWS][4];
	psum_t       zk_d      [NUM_ROWS][2];
	clip_t       corner_d  [NUM_ROWS][NUM_CORNERS];
	plane_mask_t all_out_d;
	plane_mask_t mask_d    [NUM_CORNERS];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[ROW_X] <= ROW_X_RESET;
			row_q[ROW_Y] <= ROW_Y_RESET;
			row_q[ROW_Z] <= ROW_Z_RESET;
			row_q[ROW_W] <= ROW_W_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CLIP_ROW_X: row_q[ROW_X] <= cfg_data;
				REG_CLIP_ROW_Y: row_q[ROW_Y] <= cfg_data;
				REG_CLIP_ROW_Z: row_q[ROW_Z] <= cfg_data;
				REG_CLIP_ROW_W: row_q[ROW_W] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: every x, y and z coefficient times both extremes of its axis; w coefficient passed on
	always_comb begin
		for (int r = 0; r < NUM_ROWS; r++) begin
			prod_d[r][0] = coef_t'(row_q[r][15:0])  * box_min_x;
			prod_d[r][1] = coef_t'(row_q[r][15:0])  * box_max_x;
			prod_d[r][2] = coef_t'(row_q[r][31:16]) * box_min_y;
			prod_d[r][3] = coef_t'(row_q[r][31:16]) * box_max_y;
			prod_d[r][4] = coef_t'(row_q[r][47:32]) * box_min_z;
			prod_d[r][5] = coef_t'(row_q[r][47:32]) * box_max_z;
			wcoef_d[r]   = coef_t'(row_q[r][63:48]);
		end
	end

	// Stage 2: x+y pairs for the four xy corners, z term plus homogeneous term
	always_comb begin
		for (int r = 0; r < NUM_ROWS; r++) begin
			for (int j = 0; j < 4; j++) begin
				xy_d[r][j] = psum_t'(prod_s1[r][j % 2]) + psum_t'(prod_s1[r][2 + j / 2]);
			end
			for (int k = 0; k < 2; k++) begin
				zk_d[r][k] = psum_t'(prod_s1[r][4 + k])
					+ (psum_t'(wcoef_s1[r]) <<< ONE_SHIFT);
			end
		end
	end

	// Stage 3: full clip component for each corner
	always_comb begin
		for (int r = 0; r < NUM_ROWS; r++) begin
			for (int i = 0; i < NUM_CORNERS; i++) begin
				corner_d[r][i] = clip_t'(xy_s2[r][i % 4]) + clip_t'(zk_s2[r][i / 4]);
			end
		end
	end

	// Stage 4: plane outcodes per corner, keep planes that every corner lies beyond
	always_comb begin
		all_out_d = '1;
		for (int i = 0; i < NUM_CORNERS; i++) begin
			mask_d[i][0] = corner_s3[ROW_X][i] > corner_s3[ROW_W][i];
			mask_d[i][1] = (cmp_t'(corner_s3[ROW_X][i]) + cmp_t'(corner_s3[ROW_W][i]))
				< cmp_t'(0);
			mask_d[i][2] = corner_s3[ROW_Y][i] > corner_s3[ROW_W][i];
			mask_d[i][3] = (cmp_t'(corner_s3[ROW_Y][i]) + cmp_t'(corner_s3[ROW_W][i]))
				< cmp_t'(0);
			mask_d[i][4] = corner_s3[ROW_Z][i] > corner_s3[ROW_W][i];
			mask_d[i][5] = corner_s3[ROW_Z][i] < clip_t'(0);
			all_out_d    = all_out_d & mask_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1    <= prod_d;
		wcoef_s1   <= wcoef_d;
		xy_s2      <= xy_d;
		zk_s2      <= zk_d;
		corner_s3  <= corner_d;
		visible_s4 <= (all_out_d == '0);
	end

	assign done    = v_s4;
	assign visible = visible_s4;

endmodule
